@@ sv/tmcs_pkg.sv @@
// Shared types and constants for the tile migration core selector.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tmcs_pkg;

  localparam int unsigned REQ_W  = 2;
  localparam int unsigned TILE_W = 4;
  localparam int unsigned CORE_W = 6;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned THR_W  = 8;

  localparam logic [REQ_W-1:0] REQ_SET_STATS = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET_CORE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SECURE    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_OPEN      = 2'd3;

  localparam logic [TIME_W-1:0] LIMIT_RESET = '1;

  // Write broadcast from the input channel to every cell.
  typedef struct packed {
    logic              st_we;
    logic              core_we;
    logic [TILE_W-1:0] tile;
    logic [CORE_W-1:0] core;
    logic [TIME_W-1:0] shared_time;
    logic [THR_W-1:0]  active_threads;
    logic              core_free;
  } tmcs_upd_t;

  // Scan token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic              vld;
    logic              secure;
    logic              done;
    logic              best;
    logic              no_limit;
    logic              has_free;
    logic [TILE_W-1:0] cur;
    logic [TIME_W-1:0] run_min;
    logic [CORE_W-1:0] core;
    logic [TILE_W-1:0] tile;
  } tmcs_token_t;

endpackage

`default_nettype wire

@@ sv/tmcs_ifs.sv @@
// Valid/ready channel interfaces for the tile migration core selector.
// Depends on tmcs_pkg for the field widths.
`default_nettype none

interface tmcs_in_if import tmcs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [TILE_W-1:0] tile;
  logic [CORE_W-1:0] core;
  logic [TIME_W-1:0] shared_time;
  logic [THR_W-1:0]  active_threads;
  logic              core_free;

  modport source (output valid, req_type, tile, core, shared_time, active_threads,
                  core_free, input ready);
  modport sink   (input valid, req_type, tile, core, shared_time, active_threads,
                  core_free, output ready);
endinterface

interface tmcs_out_if import tmcs_pkg::*;;
  logic              valid;
  logic              ready;
  logic              found;
  logic [CORE_W-1:0] dest_core;
  logic [TILE_W-1:0] dest_tile;

  modport source (output valid, found, dest_core, dest_tile, input ready);
  modport sink   (input valid, found, dest_core, dest_tile, output ready);
endinterface

interface tmcs_cfg_if import tmcs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ sv/tmcs_cell.sv @@
// One tile cell: holds the tile's shared time, thread count and core free bits,
// and advances the scan token by one tile per cycle. Depends on tmcs_pkg.
`default_nettype none

module tmcs_cell import tmcs_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CPT = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tmcs_upd_t         upd,
  input  tmcs_token_t       tok_in,
  output tmcs_token_t       tok_out,
  output logic [TIME_W-1:0] st_out
);

  localparam int unsigned BASE = IDX * CPT;

  logic [TIME_W-1:0] st_r, st_nxt;
  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic [CPT-1:0]    free_r, free_nxt;
  tmcs_token_t       tok_r, tok_nxt;
  logic              any_free;
  logic [CORE_W-1:0] lo_core;

  always_comb begin
    st_nxt   = st_r;
    thr_nxt  = thr_r;
    free_nxt = free_r;
    if (upd.st_we && (32'(upd.tile) == IDX)) begin
      st_nxt  = upd.shared_time;
      thr_nxt = upd.active_threads;
    end
    for (int c = 0; c < CPT; c++) begin
      if (upd.core_we && (32'(upd.core) == 32'(BASE + c))) begin
        free_nxt[c] = upd.core_free;
      end
    end
  end

  // Lowest free core on this tile; the lowest index is assigned last.
  always_comb begin
    lo_core = '0;
    for (int c = CPT - 1; c >= 0; c--) begin
      if (free_r[c]) begin
        lo_core = CORE_W'(BASE + c);
      end
    end
  end

  assign any_free = |free_r;

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.vld && !tok_in.done) begin
      if (tok_in.secure) begin
        if (st_r < tok_in.run_min) begin
          tok_nxt.best     = 1'b1;
          tok_nxt.has_free = any_free;
          tok_nxt.core     = lo_core;
          tok_nxt.tile     = TILE_W'(IDX);
          // An idle tile is taken at once and skips the limit check.
          if (thr_r == '0) begin
            tok_nxt.done     = 1'b1;
            tok_nxt.no_limit = 1'b1;
          end else begin
            tok_nxt.run_min = st_r;
          end
        end
      end else if (any_free && (32'(tok_in.cur) != IDX)) begin
        tok_nxt.done     = 1'b1;
        tok_nxt.best     = 1'b1;
        tok_nxt.has_free = 1'b1;
        tok_nxt.core     = lo_core;
        tok_nxt.tile     = TILE_W'(IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      thr_r  <= '0;
      free_r <= '0;
      tok_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      thr_r  <= thr_nxt;
      free_r <= free_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_out = tok_r;
  assign st_out  = st_r;

endmodule

`default_nettype wire

@@ sv/tile_migration_core_selector_core.sv @@
// Tile migration core selector: a chain of NUM_TILES cells, one per tile, with
// a small controller. Depends on tmcs_pkg, tmcs_ifs and tmcs_cell.
//
// Update items (stats, core free bit) may follow each other back to back. A query
// walks a scan token through the cell chain, one tile per cycle; its result is
// held in a result register and then loaded into the output register once that is
// free. The next item is accepted the cycle after the result is loaded into the
// output register. The chain length sets how long the scan lasts. All tables come
// out of reset cleared, and the limit register comes out of reset at all ones.
`default_nettype none

module tile_migration_core_selector_core import tmcs_pkg::*; #(
  parameter int unsigned NUM_TILES      = 16,
  parameter int unsigned CORES_PER_TILE = 4
) (
  input logic       clk,
  input logic       rst_n,
  tmcs_in_if.sink   in_chan,
  tmcs_out_if.source out_chan,
  tmcs_cfg_if.sink  cfg_chan
);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_SCAN, S_HOLD} state_t;

  state_t            state_r;
  logic [TILE_W-1:0] cur_r;
  logic              secure_r;
  logic [TIME_W-1:0] limit_r;
  logic              res_found_r;
  logic [CORE_W-1:0] res_core_r;
  logic [TILE_W-1:0] res_tile_r;
  logic              out_valid_r;
  logic              out_found_r;
  logic [CORE_W-1:0] out_core_r;
  logic [TILE_W-1:0] out_tile_r;

  tmcs_upd_t         upd;
  tmcs_token_t       tok [NUM_TILES+1];
  logic [TIME_W-1:0] st_all [NUM_TILES];
  logic [TIME_W-1:0] cur_st;
  logic              cur_hit;
  logic              in_xfer;
  logic              fin_ok;
  tmcs_token_t       fin;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_xfer        = in_chan.valid && in_chan.ready;

  always_comb begin
    upd                = '0;
    upd.st_we          = in_xfer && (in_chan.req_type == REQ_SET_STATS);
    upd.core_we        = in_xfer && (in_chan.req_type == REQ_SET_CORE);
    upd.tile           = in_chan.tile;
    upd.core           = in_chan.core;
    upd.shared_time    = in_chan.shared_time;
    upd.active_threads = in_chan.active_threads;
    upd.core_free      = in_chan.core_free;
  end

  // Shared time of the querying tile seeds the running minimum.
  always_comb begin
    cur_st  = '0;
    cur_hit = 1'b0;
    for (int i = 0; i < NUM_TILES; i++) begin
      if (32'(cur_r) == 32'(i)) begin
        cur_st  = st_all[i];
        cur_hit = 1'b1;
      end
    end
  end

  always_comb begin
    tok[0]         = '0;
    tok[0].vld     = (state_r == S_LOAD);
    tok[0].secure  = secure_r;
    tok[0].cur     = cur_r;
    tok[0].run_min = cur_st;
    // A secure query from a tile that does not exist finds nothing.
    tok[0].done    = secure_r && !cur_hit;
  end

  for (genvar g = 0; g < NUM_TILES; g++) begin : g_cell
    tmcs_cell #(
      .IDX (g),
      .CPT (CORES_PER_TILE)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .upd     (upd),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1]),
      .st_out  (st_all[g])
    );
  end

  assign fin    = tok[NUM_TILES];
  assign fin_ok = fin.best && fin.has_free &&
                  (!fin.secure || fin.no_limit || (fin.run_min < limit_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
      cur_r       <= '0;
      secure_r    <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        limit_r <= cfg_chan.data;
      end
      if ((state_r == S_HOLD) && (!out_valid_r || out_chan.ready)) begin
        out_valid_r <= 1'b1;
        out_found_r <= res_found_r;
        out_core_r  <= res_core_r;
        out_tile_r  <= res_tile_r;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer && ((in_chan.req_type == REQ_SECURE) ||
                          (in_chan.req_type == REQ_OPEN))) begin
            cur_r    <= in_chan.tile;
            secure_r <= (in_chan.req_type == REQ_SECURE);
            state_r  <= S_LOAD;
          end
        end
        S_LOAD: begin
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (fin.vld) begin
            res_found_r <= fin_ok;
            res_core_r  <= fin_ok ? fin.core : '0;
            res_tile_r  <= fin_ok ? fin.tile : '0;
            state_r     <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!out_valid_r || out_chan.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.found     = out_found_r;
  assign out_chan.dest_core = out_core_r;
  assign out_chan.dest_tile = out_tile_r;

endmodule

`default_nettype wire

@@ sv/tmcs_checker.sv @@
// Port-level checks for the tile migration core selector, bound to the top.
// Depends on tmcs_pkg; sees only the top level's ports.
`default_nettype none

module tmcs_checker import tmcs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [REQ_W-1:0]  in_req_type,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_found,
  input logic [CORE_W-1:0] out_dest_core,
  input logic [TILE_W-1:0] out_dest_tile
);

  // A result waiting for its transfer keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
      $stable(out_dest_core) && $stable(out_dest_tile))
    else $error("result changed while stalled");

  // A miss reports zero destination fields.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_dest_core == '0) && (out_dest_tile == '0))
    else $error("miss with nonzero destination");

  // A query occupies the block for the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && ((in_req_type == REQ_SECURE) || (in_req_type == REQ_OPEN))
      |=> !in_ready)
    else $error("input ready right after a query");

  // Updates never stall the input.
  a_update_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
      ((in_req_type == REQ_SET_STATS) || (in_req_type == REQ_SET_CORE)) |=> in_ready)
    else $error("input stalled after an update");

endmodule

bind tile_migration_core_selector_core tmcs_checker u_tmcs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_req_type   (in_chan.req_type),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_found     (out_chan.found),
  .out_dest_core (out_chan.dest_core),
  .out_dest_tile (out_chan.dest_tile)
);

`default_nettype wire
